// ----- rtl/tpcs_pkg.sv -----
// Package for the panel command stream block: item types, job descriptor,
// opcodes and the boot table. Used by every module under rtl/.
`timescale 1ns / 1ps
`default_nettype none
package tpcs_pkg;

  localparam logic [1:0] CMD_INIT   = 2'd0;
  localparam logic [1:0] CMD_FILL   = 2'd1;
  localparam logic [1:0] CMD_WINDOW = 2'd2;
  localparam logic [1:0] CMD_PIXEL  = 2'd3;

  localparam logic [1:0] KIND_CMD  = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_RUN  = 2'd2;

  localparam logic [2:0] JOB_INIT   = 3'd0;
  localparam logic [2:0] JOB_MADCTL = 3'd1;
  localparam logic [2:0] JOB_WINDOW = 3'd2;
  localparam logic [2:0] JOB_FILL   = 3'd3;
  localparam logic [2:0] JOB_PIXEL  = 3'd4;

  localparam logic [1:0] REG_COL_OFFSET = 2'd0;
  localparam logic [1:0] REG_ROW_OFFSET = 2'd1;
  localparam logic [1:0] REG_BGR_ORDER  = 2'd2;

  localparam logic [7:0] OP_CASET     = 8'h2A;
  localparam logic [7:0] OP_RASET     = 8'h2B;
  localparam logic [7:0] OP_RAMWR     = 8'h2C;
  localparam logic [7:0] OP_MADCTL    = 8'h36;
  localparam logic [7:0] MADCTL_BASE  = 8'h60;
  localparam logic [7:0] MADCTL_BGR   = 8'h08;
  localparam logic [4:0] FINAL_ENTRY  = 5'd18;
  localparam logic [8:0] MAX_SIDE     = 9'd256;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic [8:0]         width;
    logic [8:0]         height;
    logic [15:0]        color;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] value;
    logic [16:0] repeat_count;
    logic [7:0]  delay_after_ms;
    logic        init_complete;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] column_offset;
    logic [7:0] row_offset;
    logic       bgr_order;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  job;
    logic [4:0]  entry;
    logic        bgr;
    logic [15:0] x0;
    logic [15:0] x1;
    logic [15:0] y0;
    logic [15:0] y1;
    logic [16:0] run;
    logic [15:0] color;
  } desc_t;

  typedef struct packed {
    logic [7:0]        op;
    logic [4:0]        nargs;
    logic [15:0][7:0]  args;
    logic [7:0]        delay;
  } init_row_t;

  function automatic init_row_t init_row_f(input logic [4:0] e);
    init_row_t r;
    r = '0;
    case (e)
      5'd0: begin r.op = 8'h01; r.delay = 8'd150; end
      5'd1: begin r.op = 8'h11; r.delay = 8'd200; end
      5'd2: begin r.op = 8'hB1; r.nargs = 5'd3; r.args = 128'h2D2C01; end
      5'd3: begin r.op = 8'hB2; r.nargs = 5'd3; r.args = 128'h2D2C01; end
      5'd4: begin r.op = 8'hB3; r.nargs = 5'd6; r.args = 128'h2D2C012D2C01; end
      5'd5: begin r.op = 8'hB4; r.nargs = 5'd1; r.args = 128'h07; end
      5'd6: begin r.op = 8'hC0; r.nargs = 5'd3; r.args = 128'h8402A2; end
      5'd7: begin r.op = 8'hC1; r.nargs = 5'd1; r.args = 128'hC5; end
      5'd8: begin r.op = 8'hC2; r.nargs = 5'd2; r.args = 128'h000A; end
      5'd9: begin r.op = 8'hC3; r.nargs = 5'd2; r.args = 128'h2A8A; end
      5'd10: begin r.op = 8'hC4; r.nargs = 5'd2; r.args = 128'hEE8A; end
      5'd11: begin r.op = 8'hC5; r.nargs = 5'd1; r.args = 128'h0E; end
      5'd12: begin r.op = 8'h21; end
      5'd13: begin r.op = 8'h3A; r.nargs = 5'd1; r.args = 128'h05; end
      5'd14: begin
        r.op = 8'hE0;
        r.nargs = 5'd16;
        r.args = 128'h10030100392B25292D29323712071C02;
      end
      5'd15: begin
        r.op = 8'hE1;
        r.nargs = 5'd16;
        r.args = 128'h100200003F372E2E2D292C2E06071D03;
      end
      5'd16: begin r.op = 8'h13; r.delay = 8'd10; end
      5'd17: begin r.op = 8'h29; r.delay = 8'd100; end
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/tpcs_front.sv -----
// Front end: accepts input beats, classifies them and forms job descriptors.
// Owns the init entry index. Depends on tpcs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tpcs_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire tpcs_pkg::in_item_t in_data,
  input  wire tpcs_pkg::cfg_t    cfg,
  input  wire logic              q_full,
  output logic                   q_push,
  output tpcs_pkg::desc_t        q_desc
);

  logic [4:0]  init_entry_r;
  logic [4:0]  init_entry_nxt;
  logic [4:0]  entry;
  logic [8:0]  w_sat;
  logic [8:0]  h_sat;
  logic [15:0] x0;
  logic [15:0] y0;
  logic [16:0] area;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  assign entry = (init_entry_r > tpcs_pkg::FINAL_ENTRY) ? 5'd0 : init_entry_r;
  assign w_sat = (in_data.width > tpcs_pkg::MAX_SIDE) ? tpcs_pkg::MAX_SIDE : in_data.width;
  assign h_sat = (in_data.height > tpcs_pkg::MAX_SIDE) ? tpcs_pkg::MAX_SIDE : in_data.height;
  assign x0    = in_data.x_pos + {8'd0, cfg.column_offset};
  assign y0    = in_data.y_pos + {8'd0, cfg.row_offset};
  assign area  = {8'd0, w_sat} * {8'd0, h_sat};

  always_comb begin
    q_desc       = '0;
    q_desc.entry = entry;
    q_desc.bgr   = cfg.bgr_order;
    q_desc.x0    = x0;
    q_desc.x1    = x0 + {7'd0, w_sat} - 16'd1;
    q_desc.y0    = y0;
    q_desc.y1    = y0 + {7'd0, h_sat} - 16'd1;
    q_desc.run   = area;
    q_desc.color = in_data.color;
    case (in_data.command)
      tpcs_pkg::CMD_INIT: begin
        q_desc.job = (entry == tpcs_pkg::FINAL_ENTRY) ? tpcs_pkg::JOB_MADCTL
                                                       : tpcs_pkg::JOB_INIT;
      end
      tpcs_pkg::CMD_FILL:   q_desc.job = tpcs_pkg::JOB_FILL;
      tpcs_pkg::CMD_WINDOW: q_desc.job = tpcs_pkg::JOB_WINDOW;
      tpcs_pkg::CMD_PIXEL:  q_desc.job = tpcs_pkg::JOB_PIXEL;
      default:              q_desc.job = tpcs_pkg::JOB_PIXEL;
    endcase
  end

  always_comb begin
    init_entry_nxt = init_entry_r;
    if (q_push && in_data.command == tpcs_pkg::CMD_INIT) begin
      init_entry_nxt = (entry == tpcs_pkg::FINAL_ENTRY) ? 5'd0 : entry + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_entry_r <= 5'd0;
    end else begin
      init_entry_r <= init_entry_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/tpcs_queue.sv -----
// Two-entry descriptor queue between front and back ends.
// Depends on tpcs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tpcs_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire tpcs_pkg::desc_t push_desc,
  output logic                full,
  input  wire logic           pop,
  output logic                q_valid,
  output tpcs_pkg::desc_t     q_desc
);

  tpcs_pkg::desc_t mem_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  assign full    = count_r == 2'd2;
  assign q_valid = count_r != 2'd0;
  assign q_desc  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/tpcs_back.sv -----
// Back end: steps through one job descriptor and emits one result beat per
// step into the output register. Depends on tpcs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tpcs_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid,
  input  wire tpcs_pkg::desc_t  q_desc,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output tpcs_pkg::out_item_t  out_data
);

  tpcs_pkg::desc_t     cur_r;
  logic                cur_valid_r;
  logic                cur_valid_nxt;
  logic [4:0]          step_r;
  logic [4:0]          step_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  tpcs_pkg::out_item_t out_data_r;
  tpcs_pkg::out_item_t item;
  tpcs_pkg::init_row_t row;
  logic [4:0]          last_step;
  logic [3:0]          arg_idx;
  logic                advance;
  logic                at_last;

  assign row       = tpcs_pkg::init_row_f(cur_r.entry);
  assign arg_idx   = 4'(step_r - 5'd1);
  assign advance   = cur_valid_r && (!out_valid_r || out_ready);
  assign at_last   = step_r == last_step;
  assign q_pop     = q_valid && (!cur_valid_r || (advance && at_last));
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    item              = '0;
    item.kind         = tpcs_pkg::KIND_DATA;
    item.repeat_count = 17'd1;
    last_step         = 5'd1;
    case (cur_r.job)
      tpcs_pkg::JOB_INIT: begin
        last_step = row.nargs;
        if (step_r == 5'd0) begin
          item.kind  = tpcs_pkg::KIND_CMD;
          item.value = {8'd0, row.op};
        end else begin
          item.value = {8'd0, row.args[arg_idx]};
        end
        if (step_r == row.nargs) begin
          item.delay_after_ms = row.delay;
        end
      end
      tpcs_pkg::JOB_MADCTL: begin
        if (step_r == 5'd0) begin
          item.kind  = tpcs_pkg::KIND_CMD;
          item.value = {8'd0, tpcs_pkg::OP_MADCTL};
        end else begin
          item.value = {8'd0, tpcs_pkg::MADCTL_BASE |
                       (cur_r.bgr ? tpcs_pkg::MADCTL_BGR : 8'd0)};
          item.init_complete = 1'b1;
        end
      end
      tpcs_pkg::JOB_WINDOW, tpcs_pkg::JOB_FILL: begin
        last_step = (cur_r.job == tpcs_pkg::JOB_FILL && cur_r.run != 17'd0) ? 5'd11 : 5'd10;
        case (step_r)
          5'd0: begin
            item.kind  = tpcs_pkg::KIND_CMD;
            item.value = {8'd0, tpcs_pkg::OP_CASET};
          end
          5'd1: item.value = {8'd0, cur_r.x0[15:8]};
          5'd2: item.value = {8'd0, cur_r.x0[7:0]};
          5'd3: item.value = {8'd0, cur_r.x1[15:8]};
          5'd4: item.value = {8'd0, cur_r.x1[7:0]};
          5'd5: begin
            item.kind  = tpcs_pkg::KIND_CMD;
            item.value = {8'd0, tpcs_pkg::OP_RASET};
          end
          5'd6: item.value = {8'd0, cur_r.y0[15:8]};
          5'd7: item.value = {8'd0, cur_r.y0[7:0]};
          5'd8: item.value = {8'd0, cur_r.y1[15:8]};
          5'd9: item.value = {8'd0, cur_r.y1[7:0]};
          5'd10: begin
            item.kind  = tpcs_pkg::KIND_CMD;
            item.value = {8'd0, tpcs_pkg::OP_RAMWR};
          end
          5'd11: begin
            item.kind         = tpcs_pkg::KIND_RUN;
            item.value        = cur_r.color;
            item.repeat_count = cur_r.run;
          end
          default: item.value = 16'd0;
        endcase
      end
      tpcs_pkg::JOB_PIXEL: begin
        item.value = (step_r == 5'd0) ? {8'd0, cur_r.color[15:8]} : {8'd0, cur_r.color[7:0]};
      end
      default: last_step = 5'd1;
    endcase
    item.last = step_r == last_step;
  end

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    step_nxt      = step_r;
    if (advance) begin
      if (at_last) begin
        cur_valid_nxt = q_valid;
        step_nxt      = 5'd0;
      end else begin
        step_nxt = step_r + 5'd1;
      end
    end else if (!cur_valid_r) begin
      cur_valid_nxt = q_valid;
      step_nxt      = 5'd0;
    end
    out_valid_nxt = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_desc;
    end
    if (advance) begin
      out_data_r <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      step_r      <= 5'd0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/tft_panel_command_stream.sv -----
// Top level of the panel command stream generator: APB register file,
// front end, descriptor queue and back end. Depends on tpcs_pkg, tpcs_front,
// tpcs_queue and tpcs_back.
//
// Input channel (in_valid/in_ready/in_data) takes one command per beat:
// init step, fill rectangle, open window or one image pixel. Output channel
// (out_valid/out_ready/out_data) gives one beat per panel byte or colour run,
// with last set on the final beat of each command.
// The first result beat passes through a queue entry, the current descriptor
// register and the output register. Throughput: one result beat per cycle
// from the back end sequencer while out_ready is high. A command gives 2
// beats for a pixel, 1 to 17 for an init step, 11 or 12 for window or fill.
// The two-entry queue lets the front end accept commands while the back
// end works; when out_ready is low the output register holds its beat and
// the sequencer and then the queue fill up, dropping in_ready.
// Reset clears the queue, sequencer and init index and sets all three
// registers (column offset, row offset, BGR order at 0x0, 0x4, 0x8) to zero.
`timescale 1ns / 1ps
`default_nettype none
module tft_panel_command_stream (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire tpcs_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output tpcs_pkg::out_item_t      out_data,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [3:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  logic [7:0]      col_off_r;
  logic [7:0]      col_off_nxt;
  logic [7:0]      row_off_r;
  logic [7:0]      row_off_nxt;
  logic            bgr_r;
  logic            bgr_nxt;
  logic            wr_en;
  tpcs_pkg::cfg_t  cfg;
  logic            q_full;
  logic            q_push;
  tpcs_pkg::desc_t push_desc;
  logic            q_pop;
  logic            q_valid;
  tpcs_pkg::desc_t q_desc;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    col_off_nxt = col_off_r;
    row_off_nxt = row_off_r;
    bgr_nxt     = bgr_r;
    if (wr_en) begin
      case (paddr[3:2])
        tpcs_pkg::REG_COL_OFFSET: col_off_nxt = pwdata[7:0];
        tpcs_pkg::REG_ROW_OFFSET: row_off_nxt = pwdata[7:0];
        tpcs_pkg::REG_BGR_ORDER:  bgr_nxt     = pwdata[0];
        default:                  bgr_nxt     = bgr_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      tpcs_pkg::REG_COL_OFFSET: prdata = {24'd0, col_off_r};
      tpcs_pkg::REG_ROW_OFFSET: prdata = {24'd0, row_off_r};
      tpcs_pkg::REG_BGR_ORDER:  prdata = {31'd0, bgr_r};
      default:                  prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_off_r <= 8'd0;
      row_off_r <= 8'd0;
      bgr_r     <= 1'b0;
    end else begin
      col_off_r <= col_off_nxt;
      row_off_r <= row_off_nxt;
      bgr_r     <= bgr_nxt;
    end
  end

  assign cfg.column_offset = col_off_r;
  assign cfg.row_offset    = row_off_r;
  assign cfg.bgr_order     = bgr_r;

  tpcs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg      (cfg),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_desc   (push_desc)
  );

  tpcs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (push_desc),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_desc    (q_desc)
  );

  tpcs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_desc    (q_desc),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
